// ===== design/l3bm_pkg.sv =====
// ============================================================================
// l3bm_pkg
// Types, codes and helpers shared by the three-wire bus byte master.
// ============================================================================
package l3bm_pkg;

   localparam int CNT_W = 10;

   localparam logic [2:0] OP_ADDRESS     = 3'd0;
   localparam logic [2:0] OP_FIRST_WRITE = 3'd1;
   localparam logic [2:0] OP_LATER_WRITE = 3'd2;
   localparam logic [2:0] OP_FIRST_READ  = 3'd3;
   localparam logic [2:0] OP_LATER_READ  = 3'd4;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_HALT  = 3'd1;
   localparam logic [2:0] PH_SETUP = 3'd2;
   localparam logic [2:0] PH_LOW   = 3'd3;
   localparam logic [2:0] PH_HIGH  = 3'd4;
   localparam logic [2:0] PH_HOLD  = 3'd5;

   localparam logic [2:0] REG_CLOCK_LOW  = 3'd0;
   localparam logic [2:0] REG_CLOCK_HIGH = 3'd1;
   localparam logic [2:0] REG_HALT       = 3'd2;
   localparam logic [2:0] REG_MODE_SETUP = 3'd3;
   localparam logic [2:0] REG_MODE_HOLD  = 3'd4;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic       start_req;
      logic [2:0] op;
      logic [7:0] byte_value;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_level;
      logic       scl_driven;
      logic       sda_level;
      logic       sda_driven;
      logic       mode_level;
      logic       busy_res;
      logic       byte_done;
      logic [7:0] read_byte;
   } rsp_word_type;

   typedef struct packed {
      logic mode;
      logic sda_drv;
      logic sda;
      logic scl_drv;
      logic scl;
   } pin_type;

   typedef struct packed {
      logic [2:0]       phase;
      logic [CNT_W-1:0] tick_count;
      logic [2:0]       bit_index;
      logic [7:0]       shift_byte;
      logic [2:0]       latched_op;
      pin_type          pins;
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] clock_low;
      logic [CNT_W-1:0] clock_high;
      logic [CNT_W-1:0] halt;
      logic [CNT_W-1:0] mode_setup;
      logic [CNT_W-1:0] mode_hold;
   } cfg_type;

   // a zero length is treated as a length of one
   function automatic logic [CNT_W-1:0] span(input logic [CNT_W-1:0] r);
      span = (r == '0) ? CNT_W'(1) : r;
   endfunction

   function automatic logic op_reads(input logic [2:0] op);
      op_reads = (op == OP_FIRST_READ) || (op == OP_LATER_READ);
   endfunction

endpackage

// ===== design/l3bm_step.sv =====
// ============================================================================
// l3bm_step
// One tick of the bus sequencer: next state and result word.
// ============================================================================
module l3bm_step
   import l3bm_pkg::*;
(
   input  state_type    cur,
   input  cfg_type      cfg,
   input  req_word_type req,
   output state_type    nxt,
   output rsp_word_type rsp
);

   logic             rd_new;
   logic [2:0]       op_eff;
   logic             rd_cur;
   logic [CNT_W-1:0] tick_inc;
   logic [CNT_W-1:0] len;
   logic [2:0]       low_bit;
   logic             done;
   logic [7:0]       rbyte;

   always_comb begin
      nxt      = cur;
      done     = 1'b0;
      rbyte    = '0;
      op_eff   = (req.op > OP_LATER_READ) ? OP_LATER_WRITE : req.op;
      rd_new   = op_reads(op_eff);
      rd_cur   = op_reads(cur.latched_op);
      tick_inc = cur.tick_count + CNT_W'(1);
      low_bit  = (cur.phase == PH_SETUP) ? 3'd0 : cur.bit_index + 3'd1;

      unique case (cur.phase)
         PH_HALT:  len = span(cfg.halt);
         PH_SETUP: len = span(cfg.mode_setup);
         PH_LOW:   len = span(cfg.clock_low);
         PH_HIGH:  len = span(cfg.clock_high);
         default:  len = span(cfg.mode_hold);
      endcase

      if (cur.phase == PH_IDLE) begin
         if (req.start_req) begin
            nxt.latched_op   = op_eff;
            nxt.bit_index    = '0;
            nxt.tick_count   = '0;
            nxt.shift_byte   = rd_new ? 8'd0 : req.byte_value;
            nxt.pins         = '0;
            nxt.pins.scl     = 1'b1;
            nxt.pins.scl_drv = 1'b1;
            nxt.pins.sda     = !rd_new;
            nxt.pins.sda_drv = !rd_new;
            nxt.pins.mode    = (op_eff == OP_FIRST_WRITE) || (op_eff == OP_FIRST_READ);
            nxt.phase        = ((op_eff == OP_LATER_WRITE) || (op_eff == OP_LATER_READ))
                               ? PH_HALT : PH_SETUP;
         end
      end else begin
         nxt.tick_count = tick_inc;
         if (tick_inc >= len) begin
            nxt.tick_count = '0;
            unique case (cur.phase)
               PH_HALT: begin
                  nxt.pins.mode = 1'b1;
                  nxt.phase     = PH_SETUP;
               end
               PH_LOW: begin
                  if (rd_cur && req.sda_in) begin
                     nxt.shift_byte = cur.shift_byte | (8'd1 << cur.bit_index);
                  end
                  nxt.pins.scl     = 1'b1;
                  nxt.pins.scl_drv = 1'b1;
                  nxt.phase        = PH_HIGH;
               end
               PH_SETUP, PH_HIGH: begin
                  if (cur.phase == PH_HIGH && cur.bit_index >= LAST_BIT) begin
                     nxt.pins.mode = 1'b1;
                     nxt.phase     = PH_HOLD;
                  end else begin
                     // clock falls, next bit goes out
                     nxt.bit_index    = low_bit;
                     nxt.pins.scl     = 1'b0;
                     nxt.pins.scl_drv = 1'b1;
                     nxt.pins.sda     = !rd_cur && cur.shift_byte[low_bit];
                     nxt.pins.sda_drv = !rd_cur;
                     nxt.phase        = PH_LOW;
                  end
               end
               default: begin
                  nxt.pins      = '0;
                  nxt.pins.mode = 1'b1;
                  nxt.phase     = PH_IDLE;
                  done          = 1'b1;
                  rbyte         = rd_cur ? cur.shift_byte : 8'd0;
               end
            endcase
         end
      end

      rsp.scl_level  = nxt.pins.scl;
      rsp.scl_driven = nxt.pins.scl_drv;
      rsp.sda_level  = nxt.pins.sda;
      rsp.sda_driven = nxt.pins.sda_drv;
      rsp.mode_level = nxt.pins.mode;
      rsp.busy_res   = (nxt.phase != PH_IDLE);
      rsp.byte_done  = done;
      rsp.read_byte  = rbyte;
   end

endmodule

// ===== design/l3bm_cfg.sv =====
// ============================================================================
// l3bm_cfg
// Timing register file for the bus byte master.
// ============================================================================
module l3bm_cfg
   import l3bm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [CNT_W-1:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CLOCK_LOW:  cfg_in.clock_low  = csr_data;
            REG_CLOCK_HIGH: cfg_in.clock_high = csr_data;
            REG_HALT:       cfg_in.halt       = csr_data;
            REG_MODE_SETUP: cfg_in.mode_setup = csr_data;
            REG_MODE_HOLD:  cfg_in.mode_hold  = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_low  <= CNT_W'(10);
         cfg_ff.clock_high <= CNT_W'(10);
         cfg_ff.halt       <= CNT_W'(1);
         cfg_ff.mode_setup <= CNT_W'(1);
         cfg_ff.mode_hold  <= CNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/l3_bus_byte_master_core.sv =====
// ============================================================================
// l3_bus_byte_master_core
// Three-wire bus master moving one byte per command, one tick per word.
// ============================================================================
//  channel  handshake             word
//  req      req_valid/req_stall   start_req, op, byte_value, sda_in
//  rsp      rsp_valid/rsp_stall   pin levels and drives, busy, done, read byte
//  csr      csr_valid/csr_ready   csr_index (0..4), csr_data (10 bits)
//
//  One req word per cycle while req_stall is low; its rsp word comes in the next cycle from the output register.
//  Sequencer state updates as the req word is taken; no req word is taken
//  while an rsp word is held by rsp_stall.
//  Synchronous reset: idle, mode high, other pins released, default timings.
//  csr writes are always taken (csr_ready high).
module l3_bus_byte_master_core
   import l3bm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CNT_W-1:0] csr_data
);

   state_type    state_ff;
   state_type    state_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         rsp_valid_ff;
   logic         take;
   cfg_type      cfg;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   l3bm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   l3bm_step u_step (
      .cur (state_ff),
      .cfg (cfg),
      .req (req_word),
      .nxt (state_in),
      .rsp (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         // idle, mode high, clock and data released low
         state_ff     <= {PH_IDLE, CNT_W'(0), 3'd0, 8'd0, 3'd0, 5'b10000};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== design/l3bm_checker.sv =====
// ============================================================================
// l3bm_checker
// Port-level checks for the bus byte master, bound to the top level.
// ============================================================================
module l3bm_checker
   import l3bm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("taken req word gave no rsp word");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.byte_done |-> !rsp_word.busy_res)
      else $error("busy on the done tick");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.busy_res |->
         rsp_word.mode_level && !rsp_word.scl_driven && !rsp_word.sda_driven
         && !rsp_word.scl_level && !rsp_word.sda_level)
      else $error("pins not released while idle");

   a_read_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.byte_done |-> rsp_word.read_byte == 8'd0)
      else $error("read byte outside done tick");

endmodule

bind l3_bus_byte_master_core l3bm_checker u_l3bm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
